>>> hw/rtl/bbmd_pkg.sv
// Shared types, constants and the boot image function of the banked bus memory decoder.
`default_nettype none

package bbmd_pkg;

   localparam int ADDR_W      = 22;
   localparam int DATA_W      = 16;
   localparam int ROM_WORD_W  = 16;
   localparam int BANK_W      = 2;
   localparam int BANK_WORDS  = 65536;
   localparam int PROG_IDX_W  = 18;
   localparam int WORK_WORDS  = 131072;
   localparam int WORK_AW     = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;

   // Access kinds carried by the request mode field.
   localparam logic ACCESS_READ  = 1'b0;
   localparam logic ACCESS_WRITE = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRAM_BANK     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORK_MODE        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORK_HALF_SELECT = 2'd2;

   // Work RAM layout modes.
   localparam logic WORK_LINEAR      = 1'b0;
   localparam logic WORK_INTERLEAVED = 1'b1;

   // Boot image generator: word i holds i * BOOT_MULT + BOOT_OFFSET, modulo 2^16.
   localparam logic [DATA_W-1:0] BOOT_MULT   = 16'h9E37;
   localparam logic [DATA_W-1:0] BOOT_OFFSET = 16'h5A5A;

   typedef enum logic [1:0] {
      REGION_BOOT,
      REGION_PROGRAM,
      REGION_WORK
   } region_type;

   typedef struct packed {
      region_type              region;
      logic [ROM_WORD_W-1:0]   rom_word;
      logic [PROG_IDX_W-1:0]   prog_index;
      logic [WORK_AW-1:0]      work_index;
   } decode_type;

   function automatic logic [DATA_W-1:0] boot_word(input logic [ROM_WORD_W-1:0] index);
      logic [DATA_W-1:0] product;
      product = index * BOOT_MULT;
      return product + BOOT_OFFSET;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bbmd_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module bbmd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] address,
   input  wire logic [WIDTH-1:0]         write_data,
   output      logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (write_enable) begin
            mem_ff[address] <= write_data;
         end else begin
            read_data_ff <= mem_ff[address];
         end
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bbmd_decode.sv
// Address decoder: clears mirror bits, picks the region and forms the word index of each store.
`default_nettype none

module bbmd_decode
   import bbmd_pkg::*;
#(
   parameter int PROGRAM_BANKS = 4
) (
   input  wire logic [ADDR_W-1:0] byte_address,
   input  wire logic [BANK_W-1:0] program_bank,
   input  wire logic              work_mode,
   input  wire logic              work_half_select,
   output      decode_type        decoded
);

   localparam logic [ADDR_W-1:0] MIRROR_MASK = 22'h1C0000;

   logic [ADDR_W-1:0] addr;
   logic [BANK_W:0]   bank_wrap;

   always_comb begin
      addr = byte_address & ~MIRROR_MASK;

      // Bank wraps modulo the bank count; at most three subtractions on a 2-bit value.
      bank_wrap = {1'b0, program_bank};
      for (int k = 0; k < 3; k++) begin
         if (bank_wrap >= (BANK_W+1)'(PROGRAM_BANKS)) begin
            bank_wrap = bank_wrap - (BANK_W+1)'(PROGRAM_BANKS);
         end
      end

      // With bits 18 to 20 cleared, bit 21 alone marks work RAM and bit 17 the program window.
      if (addr[21]) begin
         decoded.region = REGION_WORK;
      end else if (addr[17]) begin
         decoded.region = REGION_PROGRAM;
      end else begin
         decoded.region = REGION_BOOT;
      end

      decoded.rom_word   = addr[16:1];
      decoded.prog_index = {bank_wrap[BANK_W-1:0], addr[16:1]};
      if (work_mode == WORK_INTERLEAVED) begin
         decoded.work_index = {addr[16:1], ~work_half_select};
      end else begin
         decoded.work_index = addr[17:1];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/bbmd_rom.sv
// Boot ROM read pipeline: reduces the word address modulo the ROM size, then forms the image word.
`default_nettype none

module bbmd_rom
   import bbmd_pkg::*;
#(
   parameter int ROM_WORDS = 65536
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [ROM_WORD_W-1:0] word,
   output      logic                  done,
   output      logic [DATA_W-1:0]     data
);

   localparam int          ROM_AW      = $clog2(ROM_WORDS);
   localparam int          Q_W         = $clog2(65536 / ROM_WORDS + 1);
   localparam logic [63:0] RECIP_WIDE  = 64'h1_0000_0000 / 64'(ROM_WORDS);
   localparam logic [31:0] ROM_RECIP   = RECIP_WIDE[31:0];
   localparam int          PROD_W      = ROM_WORD_W + 32;

   logic                  v1_ff, v2_ff, v3_ff;
   logic [ROM_WORD_W-1:0] x1_ff;
   logic [Q_W-1:0]        q1_ff;
   logic [ROM_AW-1:0]     idx2_ff;
   logic [DATA_W-1:0]     data_ff;

   logic [PROD_W-1:0]     prod1_in;
   logic [Q_W-1:0]        q1_in;
   logic [ROM_WORD_W:0]   qd2;
   logic [ROM_WORD_W:0]   rem2;
   logic [ROM_AW-1:0]     idx2_in;

   // The reciprocal estimate is at most one low, so one compare and subtract finishes it.
   always_comb begin
      prod1_in = PROD_W'(word) * PROD_W'(ROM_RECIP);
      q1_in    = prod1_in[32 +: Q_W];
      qd2      = (ROM_WORD_W+1)'(q1_ff) * (ROM_WORD_W+1)'(ROM_WORDS);
      rem2     = (ROM_WORD_W+1)'(x1_ff) - qd2;
      if (rem2 >= (ROM_WORD_W+1)'(ROM_WORDS)) begin
         rem2 = rem2 - (ROM_WORD_W+1)'(ROM_WORDS);
      end
      idx2_in  = rem2[ROM_AW-1:0];
   end

   always_ff @(posedge clock) begin
      x1_ff   <= word;
      q1_ff   <= q1_in;
      idx2_ff <= idx2_in;
      data_ff <= boot_word(ROM_WORD_W'(idx2_ff));
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign done = v3_ff;
   assign data = data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/banked_bus_memory_decoder.sv
// Top level of the banked bus memory decoder: request handling, memories and response register.
`default_nettype none

// The block takes one 22-bit bus request at a time. Address bits 18 to 20 are
// mirror bits and are ignored, so every address lands in one of three regions:
// the boot ROM (0x000000-0x01FFFF), a 128 KiB window into banked program RAM
// (0x020000-0x03FFFF, bank chosen by program_bank modulo PROGRAM_BANKS), and
// work RAM (0x200000-0x23FFFF), either linear or word-interleaved with the
// inverse of work_half_select as the low word-index bit. Because of the mirror
// clearing there is no unmapped address, so the open-bus echo never occurs.
// Reads return exactly one response; writes return none and honor the two
// byte-lane enables. Writes to the boot ROM are dropped. During video DMA a
// work RAM read returns the word captured by the previous such read and then
// captures the word just addressed.
// Program and work RAM live in single-port synchronous RAMs with a registered
// read. A RAM read passes through S_READ, and S_SEND while the response
// register is full, before the next request is taken; a RAM write is a
// read-modify-write on the same port and passes through S_MERGE; a boot ROM
// read waits in S_ROM for the three-stage ROM unit (address reduction modulo
// ROM_WORDS and the image multiply); a write to the boot ROM region leaves the
// block in S_IDLE. The response register is separate, so a new request is
// taken while a response waits; if the response register is still full when
// the next result is ready, the block holds that result until it drains.
// Configuration writes take effect at the next request. Program and work RAM
// contents are undefined until written; there is no clearing pass.

module banked_bus_memory_decoder
   import bbmd_pkg::*;
#(
   parameter int ROM_WORDS     = 65536,
   parameter int PROGRAM_BANKS = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_mode,
   input  wire logic [ADDR_W-1:0]      req_byte_address,
   input  wire logic [DATA_W-1:0]      req_bus_data,
   input  wire logic                   req_upper_enable,
   input  wire logic                   req_lower_enable,
   input  wire logic                   req_video_dma_active,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [DATA_W-1:0]      rsp_read_data,

   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int PROG_DEPTH = PROGRAM_BANKS * BANK_WORDS;
   localparam int PROG_AW    = $clog2(PROG_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MERGE,
      S_ROM,
      S_SEND
   } state_type;

   // Configuration registers.
   logic [BANK_W-1:0] program_bank_ff;
   logic              work_mode_ff;
   logic              work_half_select_ff;

   // Control state and registered outputs.
   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [DATA_W-1:0] latch_ff, latch_in;

   // Request captured at acceptance for the following cycles.
   region_type        region_ff;
   logic [PROG_AW-1:0] prog_index_ff;
   logic [WORK_AW-1:0] work_index_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic              upper_ff;
   logic              lower_ff;
   logic              dma_ff;

   decode_type        decoded;
   logic              accept;
   logic              rsp_free;
   logic              produce;
   logic              load_rsp;
   logic              dma_read;
   logic [DATA_W-1:0] rdata_sel;
   logic [DATA_W-1:0] ram_result;
   logic [DATA_W-1:0] result;
   logic [DATA_W-1:0] merged;

   logic              prog_en, prog_we;
   logic [PROG_AW-1:0] prog_addr;
   logic [DATA_W-1:0] prog_rdata;
   logic              work_en, work_we;
   logic [WORK_AW-1:0] work_addr;
   logic [DATA_W-1:0] work_rdata;

   logic              rom_start;
   logic              rom_done;
   logic [DATA_W-1:0] rom_data;

   // ------------------------------------------------------------------
   // Configuration port. Unknown indexes are ignored.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         program_bank_ff     <= '0;
         work_mode_ff        <= WORK_LINEAR;
         work_half_select_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROGRAM_BANK:     program_bank_ff     <= csr_write_data[BANK_W-1:0];
            CSR_WORK_MODE:        work_mode_ff        <= csr_write_data[0];
            CSR_WORK_HALF_SELECT: work_half_select_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Address decode of the incoming request.
   // ------------------------------------------------------------------
   bbmd_decode #(
      .PROGRAM_BANKS(PROGRAM_BANKS)
   ) u_decode (
      .byte_address    (req_byte_address),
      .program_bank    (program_bank_ff),
      .work_mode       (work_mode_ff),
      .work_half_select(work_half_select_ff),
      .decoded         (decoded)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (accept) begin
         region_ff     <= decoded.region;
         prog_index_ff <= decoded.prog_index[PROG_AW-1:0];
         work_index_ff <= decoded.work_index;
         wdata_ff      <= req_bus_data;
         upper_ff      <= req_upper_enable;
         lower_ff      <= req_lower_enable;
         dma_ff        <= req_video_dma_active;
      end
   end

   // ------------------------------------------------------------------
   // Memories. The addressed RAM is read at acceptance; a write then merges the
   // byte lanes into the word read back and stores it in the S_MERGE cycle.
   // Only one request is in flight, so a read and its write-back never
   // overlap with another access to the same entry.
   // ------------------------------------------------------------------
   assign rdata_sel = (region_ff == REGION_WORK) ? work_rdata : prog_rdata;
   assign merged    = {upper_ff ? wdata_ff[15:8] : rdata_sel[15:8],
                       lower_ff ? wdata_ff[7:0]  : rdata_sel[7:0]};

   assign prog_we   = (state_ff == S_MERGE) && (region_ff == REGION_PROGRAM);
   assign prog_en   = (accept && (decoded.region == REGION_PROGRAM)) || prog_we;
   assign prog_addr = prog_we ? prog_index_ff : decoded.prog_index[PROG_AW-1:0];

   assign work_we   = (state_ff == S_MERGE) && (region_ff == REGION_WORK);
   assign work_en   = (accept && (decoded.region == REGION_WORK)) || work_we;
   assign work_addr = work_we ? work_index_ff : decoded.work_index;

   bbmd_ram #(
      .WIDTH(DATA_W),
      .DEPTH(PROG_DEPTH)
   ) u_program_ram (
      .clock       (clock),
      .enable      (prog_en),
      .write_enable(prog_we),
      .address     (prog_addr),
      .write_data  (merged),
      .read_data   (prog_rdata)
   );

   bbmd_ram #(
      .WIDTH(DATA_W),
      .DEPTH(WORK_WORDS)
   ) u_work_ram (
      .clock       (clock),
      .enable      (work_en),
      .write_enable(work_we),
      .address     (work_addr),
      .write_data  (merged),
      .read_data   (work_rdata)
   );

   // The boot ROM is a generated image, computed rather than stored.
   assign rom_start = accept && (req_mode == ACCESS_READ) && (decoded.region == REGION_BOOT);

   bbmd_rom #(
      .ROM_WORDS(ROM_WORDS)
   ) u_rom (
      .clock(clock),
      .reset(reset),
      .start(rom_start),
      .word (decoded.rom_word),
      .done (rom_done),
      .data (rom_data)
   );

   // ------------------------------------------------------------------
   // Result selection. A work RAM read under video DMA answers with the
   // latch and refills it with the word just read.
   // ------------------------------------------------------------------
   assign dma_read   = (region_ff == REGION_WORK) && dma_ff;
   assign ram_result = dma_read ? latch_ff : rdata_sel;
   assign result     = (state_ff == S_ROM) ? rom_data : ram_result;
   assign produce    = (state_ff == S_READ) || ((state_ff == S_ROM) && rom_done);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign load_rsp   = (produce || (state_ff == S_SEND)) && rsp_free;

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      latch_in = latch_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == ACCESS_WRITE) begin
                  // Writes to the boot ROM region are dropped right away.
                  state_in = (decoded.region == REGION_BOOT) ? S_IDLE : S_MERGE;
               end else begin
                  state_in = (decoded.region == REGION_BOOT) ? S_ROM : S_READ;
               end
            end
         end
         S_READ: begin
            state_in = rsp_free ? S_IDLE : S_SEND;
            res_in   = ram_result;
            if (dma_read) begin
               latch_in = work_rdata;
            end
         end
         S_MERGE: begin
            state_in = S_IDLE;
         end
         S_ROM: begin
            if (rom_done) begin
               state_in = rsp_free ? S_IDLE : S_SEND;
               res_in   = rom_data;
            end
         end
         S_SEND: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (state_ff == S_SEND) ? res_ff : result;
      end else begin
         rsp_valid_in = rsp_free ? 1'b0 : rsp_valid_ff;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         latch_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         latch_ff     <= latch_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_rom_done_when_waiting: assert property (
      @(posedge clock) disable iff (reset)
      rom_done |-> (state_ff == S_ROM)
   ) else $error("boot ROM result arrived while no ROM read was pending");

   a_no_response_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || !rsp_stall)
   ) else $error("response register loaded while a stalled response was pending");

   a_single_write_back: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> $onehot({prog_we, work_we})
   ) else $error("write-back must target exactly one RAM");

   a_write_gives_no_response: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |=> !$rose(rsp_valid_ff)
   ) else $error("a write produced a response");

endmodule

`default_nettype wire
